FILE: rtl/ssig_pkg.sv
// shared types, constants and the window step decoder of the stencil index generator
// no dependencies
`default_nettype none

package ssig_pkg;

  localparam int COORD_W         = 10;
  localparam int EXT_W           = 11;
  localparam int IDX_W           = 20;
  localparam int PROD_W          = COORD_W + EXT_W;
  localparam int CFG_IDX_W       = 8;
  localparam int MAX_EXTENT_DEF  = 1024;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int STEP_W          = 4;

  localparam logic [STEP_W-1:0] LAST_STEP = 4'd8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EXTENT_I = 8'd0,
    REG_EXTENT_J = 8'd1
  } reg_index_t;

  // one classified node as it waits between front and back
  typedef struct packed {
    logic               bad;
    logic               interior;
    logic [COORD_W-1:0] base_i;
    logic               down_i;
    logic [COORD_W-1:0] base_j;
    logic               down_j;
    logic [IDX_W-1:0]   eq;
  } queue_entry_t;

  // offsets into the 3x3 window scan for one step
  typedef struct packed {
    logic [1:0] a;
    logic [1:0] b;
  } win_pos_t;

  // interior nodes put the centre first and skip it later
  function automatic win_pos_t step_pos(input logic [STEP_W-1:0] k, input logic interior);
    win_pos_t p;
    p = '0;
    if (interior) begin
      unique case (k)
        4'd0:    p = '{a: 2'd1, b: 2'd1};
        4'd1:    p = '{a: 2'd0, b: 2'd0};
        4'd2:    p = '{a: 2'd1, b: 2'd0};
        4'd3:    p = '{a: 2'd2, b: 2'd0};
        4'd4:    p = '{a: 2'd0, b: 2'd1};
        4'd5:    p = '{a: 2'd2, b: 2'd1};
        4'd6:    p = '{a: 2'd0, b: 2'd2};
        4'd7:    p = '{a: 2'd1, b: 2'd2};
        4'd8:    p = '{a: 2'd2, b: 2'd2};
        default: p = '0;
      endcase
    end else begin
      unique case (k)
        4'd0:    p = '{a: 2'd0, b: 2'd0};
        4'd1:    p = '{a: 2'd1, b: 2'd0};
        4'd2:    p = '{a: 2'd2, b: 2'd0};
        4'd3:    p = '{a: 2'd0, b: 2'd1};
        4'd4:    p = '{a: 2'd1, b: 2'd1};
        4'd5:    p = '{a: 2'd2, b: 2'd1};
        4'd6:    p = '{a: 2'd0, b: 2'd2};
        4'd7:    p = '{a: 2'd1, b: 2'd2};
        4'd8:    p = '{a: 2'd2, b: 2'd2};
        default: p = '0;
      endcase
    end
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ssig_front.sv
// front end: checks a node against the grid, picks the scan start per axis, forms the row index
// depends on ssig_pkg
`default_nettype none

module ssig_front (
  input  wire logic [ssig_pkg::COORD_W-1:0] node_i,
  input  wire logic [ssig_pkg::COORD_W-1:0] node_j,
  input  wire logic [ssig_pkg::EXT_W-1:0]   extent_i,
  input  wire logic [ssig_pkg::EXT_W-1:0]   extent_j,
  output ssig_pkg::queue_entry_t            entry
);
  import ssig_pkg::*;

  logic              bad;
  logic              int_i;
  logic              int_j;
  logic [PROD_W-1:0] eq_sum;

  always_comb begin
    bad = (extent_i < EXT_W'(3)) || (extent_j < EXT_W'(3)) ||
          ({1'b0, node_i} >= extent_i) || ({1'b0, node_j} >= extent_j);

    entry.bad = bad;

    // axis i: low edge scans up from 0, high edge scans down from the node
    int_i = 1'b0;
    if (node_i == '0) begin
      entry.base_i = '0;
      entry.down_i = 1'b0;
    end else if ({1'b0, node_i} == EXT_W'(extent_i - EXT_W'(1))) begin
      entry.base_i = node_i;
      entry.down_i = 1'b1;
    end else begin
      entry.base_i = node_i - COORD_W'(1);
      entry.down_i = 1'b0;
      int_i        = 1'b1;
    end

    int_j = 1'b0;
    if (node_j == '0) begin
      entry.base_j = '0;
      entry.down_j = 1'b0;
    end else if ({1'b0, node_j} == EXT_W'(extent_j - EXT_W'(1))) begin
      entry.base_j = node_j;
      entry.down_j = 1'b1;
    end else begin
      entry.base_j = node_j - COORD_W'(1);
      entry.down_j = 1'b0;
      int_j        = 1'b1;
    end

    entry.interior = int_i && int_j;

    eq_sum   = PROD_W'(node_i) * PROD_W'(extent_j) + PROD_W'(node_j);
    entry.eq = bad ? '0 : eq_sum[IDX_W-1:0];
  end

endmodule

`default_nettype wire

FILE: rtl/ssig_queue.sv
// short flop queue of classified nodes between front and back
// depends on ssig_pkg
`default_nettype none

module ssig_queue #(
  parameter int DEPTH = ssig_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire ssig_pkg::queue_entry_t push_data,
  output logic                       full,
  input  wire logic                  pop,
  output logic                       head_valid,
  output ssig_pkg::queue_entry_t     head
);
  import ssig_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  queue_entry_t       store [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = store[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_full_push_blocked: assert property (@(posedge clk) disable iff (rst)
    (full && !do_pop) |=> full)
    else $error("full queue lost an entry without a pop");

  a_empty_stays: assert property (@(posedge clk) disable iff (rst)
    (!head_valid && !push) |=> !head_valid)
    else $error("queue filled without a push");

endmodule

`default_nettype wire

FILE: rtl/ssig_back.sv
// back end: steps through the window of the head node and forms one index pair per cycle while pair_stall is low
// depends on ssig_pkg
`default_nettype none

module ssig_back (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [ssig_pkg::EXT_W-1:0] extent_j,
  input  wire logic                       head_valid,
  input  wire ssig_pkg::queue_entry_t     head,
  output logic                            pop,
  output logic                            pair_valid,
  input  wire logic                       pair_stall,
  output logic [ssig_pkg::IDX_W-1:0]      eq_index,
  output logic [ssig_pkg::IDX_W-1:0]      var_index,
  output logic                            last_of_node,
  output logic                            bad_node
);
  import ssig_pkg::*;

  logic                en;
  logic                issue;
  logic                last_step;
  logic [STEP_W-1:0]   k;
  win_pos_t            pos;
  logic [COORD_W-1:0]  coord_i;
  logic [COORD_W-1:0]  coord_j;
  logic [PROD_W-1:0]   lin;

  // coordinate stage
  logic                a_valid;
  logic [COORD_W-1:0]  a_i;
  logic [COORD_W-1:0]  a_j;
  logic [IDX_W-1:0]    a_eq;
  logic                a_last;
  logic                a_bad;

  assign en        = !pair_valid || !pair_stall;
  assign issue     = en && head_valid;
  assign last_step = head.bad || (k == LAST_STEP);
  assign pop       = issue && last_step;

  always_comb begin
    pos     = step_pos(k, head.interior);
    coord_i = head.down_i ? head.base_i - COORD_W'(pos.a) : head.base_i + COORD_W'(pos.a);
    coord_j = head.down_j ? head.base_j - COORD_W'(pos.b) : head.base_j + COORD_W'(pos.b);
    lin     = PROD_W'(a_i) * PROD_W'(extent_j) + PROD_W'(a_j);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k          <= '0;
      a_valid    <= 1'b0;
      pair_valid <= 1'b0;
    end else begin
      if (issue) begin
        k <= last_step ? '0 : k + STEP_W'(1);
      end
      if (en) begin
        a_valid    <= issue;
        pair_valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_i    <= coord_i;
      a_j    <= coord_j;
      a_eq   <= head.eq;
      a_last <= last_step;
      a_bad  <= head.bad;
    end
    if (en && a_valid) begin
      eq_index     <= a_eq;
      var_index    <= a_bad ? '0 : lin[IDX_W-1:0];
      last_of_node <= a_last;
      bad_node     <= a_bad;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (rst)
    k <= LAST_STEP)
    else $error("window step counter out of range");

  a_pop_restarts: assert property (@(posedge clk) disable iff (rst)
    pop |=> (k == '0))
    else $error("step counter not restarted after the last pair");

  a_bad_result: assert property (@(posedge clk) disable iff (rst)
    (pair_valid && bad_node) |-> (last_of_node && eq_index == '0 && var_index == '0))
    else $error("error result not marked last or indices not zero");

endmodule

`default_nettype wire

FILE: rtl/stencil_sparsity_index_generator.sv
// top level of the nine-point stencil index generator: extent registers, front, queue, back
// depends on ssig_pkg, ssig_front, ssig_queue, ssig_back
`default_nettype none

// For each grid node (node_i, node_j) taken on the node channel the block sends nine
// (eq_index, var_index) pairs on the pair channel, last_of_node marking the ninth; a node
// outside the grid, or any extent below 3, gives a single pair with bad_node and
// last_of_node set and both indices zero. The sustained rate is set by the back end,
// whose one index multiplier produces one pair per cycle while pair_stall is low. The
// first pair of a node passes the queue, the coordinate stage and the pair register.
// The front end classifies a node in the cycle it arrives and parks it in a QUEUE_DEPTH
// entry queue, so new nodes are taken while earlier pairs still drain. Extents are written
// through the cfg port (index 0 extent_i, index 1 extent_j, other indices ignored), values
// above MAX_EXTENT saturate; write them only while no node is in flight.
module stencil_sparsity_index_generator #(
  parameter int QUEUE_DEPTH = ssig_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ssig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ssig_pkg::EXT_W-1:0]     cfg_data,
  input  wire logic                           node_valid,
  output logic                                node_stall,
  input  wire logic [ssig_pkg::COORD_W-1:0]   node_i,
  input  wire logic [ssig_pkg::COORD_W-1:0]   node_j,
  output logic                                pair_valid,
  input  wire logic                           pair_stall,
  output logic [ssig_pkg::IDX_W-1:0]          eq_index,
  output logic [ssig_pkg::IDX_W-1:0]          var_index,
  output logic                                last_of_node,
  output logic                                bad_node
);
  import ssig_pkg::*;

  localparam int MAX_EXTENT   = MAX_EXTENT_DEF;
  localparam int EXT_MAX_CODE = (1 << EXT_W) - 1;
  localparam logic [EXT_W-1:0] EXT_SAT =
    EXT_W'((MAX_EXTENT > EXT_MAX_CODE) ? EXT_MAX_CODE : MAX_EXTENT);

  logic [EXT_W-1:0] extent_i;
  logic [EXT_W-1:0] extent_j;
  logic [EXT_W-1:0] cfg_sat;
  queue_entry_t     front_entry;
  queue_entry_t     head;
  logic             head_valid;
  logic             queue_full;
  logic             pop;

  assign cfg_ready  = 1'b1;
  assign cfg_sat    = (cfg_data > EXT_SAT) ? EXT_SAT : cfg_data;
  assign node_stall = queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      extent_i <= EXT_W'(3);
      extent_j <= EXT_W'(3);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXTENT_I: extent_i <= cfg_sat;
        REG_EXTENT_J: extent_j <= cfg_sat;
        default: ;
      endcase
    end
  end

  ssig_front u_front (
    .node_i   (node_i),
    .node_j   (node_j),
    .extent_i (extent_i),
    .extent_j (extent_j),
    .entry    (front_entry)
  );

  ssig_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (node_valid && !node_stall),
    .push_data  (front_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  ssig_back u_back (
    .clk          (clk),
    .rst          (rst),
    .extent_j     (extent_j),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .pair_valid   (pair_valid),
    .pair_stall   (pair_stall),
    .eq_index     (eq_index),
    .var_index    (var_index),
    .last_of_node (last_of_node),
    .bad_node     (bad_node)
  );

endmodule

`default_nettype wire
